// ===== rtl/lf2srgb_pkg.sv =====
`default_nettype none

package lf2srgb_pkg;

	// Threshold table geometry.
	// Codes 1..255 each have a first float pattern that reaches them.
	localparam int NUM_THR = 255;
	// Result words that can cross inside one bucket of the coarse table.
	localparam int NSLOT = 8;
	// Exponent band [2^-15, 2) is bucketed; the pattern bits [30:27] are 0111 there.
	localparam logic [3:0] BAND_TOP = 4'h7;
	// Marks an unused slot: never reached by a 19-bit offset.
	localparam logic [19:0] OFF_NONE = 20'h80000;
	// Pattern of 1.0: everything at or above clamps to full scale.
	localparam logic [31:0] ONE_BITS = 32'h3F80_0000;
	localparam logic [7:0] EXP_ALL_ONES = 8'hFF;

	typedef logic [383:0] big_t;
	typedef logic [NUM_THR-1:0][30:0] thr_t;

	typedef struct packed {
		logic [7:0] base;
		logic [NSLOT-1:0][19:0] off;
	} row_t;

	typedef row_t [255:0] rom_t;

	function automatic big_t pow12(input logic [15:0] v);
		big_t r;
		r = big_t'(1);
		for (int i = 0; i < 12; i++) begin
			r = r * {368'd0, v};
		end
		return r;
	endfunction

	localparam big_t C12 = pow12(16'd10761);

	// True when the exact transfer curve rounds pattern b to code k or above.
	// p12 is (40k+541)^12.
	function automatic logic reaches(input logic [31:0] b, input logic [7:0] k,
		input big_t p12);
		logic [7:0] ex;
		logic [23:0] m;
		logic [7:0] s;
		logic [63:0] p2;
		big_t lhs;
		big_t rhs;
		logic r;
		ex = b[30:23];
		if (ex == 8'd0) begin
			m = {1'b0, b[22:0]};
			s = 8'd149;
		end else begin
			m = {1'b1, b[22:0]};
			s = 8'd150 - ex;
		end
		p2 = '0;
		lhs = '0;
		rhs = '0;
		if (b[31] || b == 32'd0) begin
			r = 1'b0;
		end else if (b >= ONE_BITS) begin
			r = 1'b1;
		end else if (s > 8'd40) begin
			r = 1'b0;
		end else begin
			p2 = 64'd1 << s;
			if ({40'd0, m} * 64'd10000000 <= 64'd31308 * p2) begin
				// linear segment, round half up
				r = ({40'd0, m} * 64'd65892 + 64'd10 * p2) >= ({56'd0, k} * 64'd20 * p2);
			end else begin
				// power segment: x^5 * 10761^12 against ((k-0.5)/255 curve point)^12
				lhs = {360'd0, m};
				for (int i = 0; i < 4; i++) begin
					lhs = lhs * {360'd0, m};
				end
				lhs = lhs * C12;
				rhs = p12 << (5 * int'(s));
				r = lhs >= rhs;
			end
		end
		return r;
	endfunction

	// First positive pattern reaching each code, by bisection (curve is monotonic).
	function automatic thr_t build_thr();
		thr_t t;
		big_t p;
		logic [31:0] lo;
		logic [31:0] hi;
		logic [31:0] mid;
		t = '0;
		for (int k = 1; k <= NUM_THR; k++) begin
			p = pow12(16'(40 * k + 541));
			lo = 32'd0;
			hi = ONE_BITS;
			for (int it = 0; it < 31; it++) begin
				if (hi - lo > 32'd1) begin
					mid = lo + ((hi - lo) >> 1);
					if (reaches(mid, 8'(k), p)) begin
						hi = mid;
					end else begin
						lo = mid;
					end
				end
			end
			t[k-1] = hi[30:0];
		end
		return t;
	endfunction

	localparam thr_t THR = build_thr();

	// Coarse table: bucket = exponent low nibble and top 4 mantissa bits.
	// base = code at bucket start, off = thresholds inside the bucket.
	function automatic rom_t build_rom();
		rom_t rom;
		logic [30:0] bs;
		logic [30:0] diff;
		int base;
		int n;
		for (int r = 0; r < 256; r++) begin
			bs = {BAND_TOP, 8'(r), 19'd0};
			base = 0;
			n = 0;
			rom[r].off = {NSLOT{OFF_NONE}};
			for (int k = 0; k < NUM_THR; k++) begin
				if (THR[k] <= bs) begin
					base = base + 1;
				end else if (THR[k] < bs + 31'h80000 && n < NSLOT) begin
					diff = THR[k] - bs;
					rom[r].off[n] = {1'b0, diff[18:0]};
					n = n + 1;
				end
			end
			rom[r].base = 8'(base);
		end
		return rom;
	endfunction

	localparam rom_t ENC_ROM = build_rom();

	function automatic logic nonfinite(input logic [31:0] b);
		return b[30:23] == EXP_ALL_ONES;
	endfunction

	// One channel: table row, then a thermometer count over the slots.
	function automatic logic [7:0] chan_code(input logic [31:0] b);
		row_t row;
		logic [3:0] cnt;
		logic [7:0] code;
		row = ENC_ROM[b[26:19]];
		cnt = '0;
		for (int j = 0; j < NSLOT; j++) begin
			if ({1'b0, b[18:0]} >= row.off[j]) begin
				cnt = cnt + 4'd1;
			end
		end
		if (b[31] || b[30:27] < BAND_TOP) begin
			code = 8'd0;
		end else if (b[30:27] > BAND_TOP) begin
			code = 8'hFF;
		end else begin
			code = row.base + {4'd0, cnt};
		end
		return code;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/linear_float_to_srgb8_encoder.sv =====
`default_nettype none

// Linear float RGBA to 8-bit sRGB encoder.
// Input channel (s_*): one pixel per word, four IEEE single-precision patterns
//   in s_tdata, red in the low 32 bits, then green, blue, alpha.
// Output channel (m_*): three sRGB codes in m_tdata, red in the low byte;
//   m_tuser[0] flags a pixel with any NaN or infinite channel (codes are 0).
// Codes are rounded half up from the exact transfer curve; negatives give 0,
//   values of 1.0 and above give 255.
// Path: an accepted word passes the input register, then the result register,
//   before it is shown on m_tdata.
// Throughput: one word per clock while m_tready is high. Each channel reads one row of a 256-entry
//   constant table and compares its low mantissa bits against eight offsets,
//   all between the two registers.
// Stall: when m_tready is low the result register holds; the input register
//   still takes one more word, and s_tready drops only when both are full.
// Reset: arst_n clears both valid flags; no word is in flight afterwards.
module linear_float_to_srgb8_encoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [127:0] s_tdata,   // red_bits, green_bits, blue_bits, alpha_bits
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic [23:0]       m_tdata,   // red_code, green_code, blue_code
	output logic [0:0]        m_tuser    // invalid
);
	import lf2srgb_pkg::*;

	logic         vld_s1;
	logic [127:0] pix_s1;
	logic         vld_s2;
	logic [23:0]  codes_s2;
	logic         inv_s2;
	logic         adv_s2;

	logic         inv_c;
	logic [7:0]   red_c;
	logic [7:0]   green_c;
	logic [7:0]   blue_c;

	// result register free or draining this cycle
	assign adv_s2   = !vld_s2 || m_tready;
	assign s_tready = !vld_s1 || adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pix_s1 <= s_tdata;
		end
	end

	// encode: any non-finite channel, alpha included, zeroes the pixel
	always_comb begin
		inv_c = nonfinite(pix_s1[31:0]) || nonfinite(pix_s1[63:32]) ||
			nonfinite(pix_s1[95:64]) || nonfinite(pix_s1[127:96]);
		red_c   = chan_code(pix_s1[31:0]);
		green_c = chan_code(pix_s1[63:32]);
		blue_c  = chan_code(pix_s1[95:64]);
		if (inv_c) begin
			red_c   = 8'd0;
			green_c = 8'd0;
			blue_c  = 8'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && vld_s1) begin
			codes_s2 <= {blue_c, green_c, red_c};
			inv_s2   <= inv_c;
		end
	end

	assign m_tvalid   = vld_s2;
	assign m_tdata    = codes_s2;
	assign m_tuser[0] = inv_s2;

`ifndef SYNTHESIS
	a_inv_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == 24'd0)
		else $error("invalid pixel with nonzero codes");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> vld_s1 && vld_s2)
		else $error("input stalled with a free stage");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && adv_s2 |=> m_tvalid)
		else $error("pending word not moved to output");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !vld_s1 |=> !m_tvalid)
		else $error("output word repeated");

	a_neg_red: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && pix_s1[31] |-> red_c == 8'd0)
		else $error("negative red encoded nonzero");
`endif

endmodule

`default_nettype wire
